// File: design/adv_pkg.sv
`timescale 1ns / 1ps
package adv_pkg;
  localparam int unsigned HdrBytes = 20;
  localparam int unsigned DefMaxEntries = 1048576;
  localparam int unsigned DefMaxNameLen = 4096;
  localparam int unsigned DefMaxDirBytes = 67108864;

  typedef enum logic [1:0] {
    KIND_ENTRY  = 2'd0,
    KIND_NAME   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [4:0] {
    ST_OK        = 5'd0,
    ST_SHORT     = 5'd1,
    ST_TABLE     = 5'd2,
    ST_COUNT     = 5'd3,
    ST_DIR_LIMIT = 5'd4,
    ST_NAMES     = 5'd5,
    ST_BOUNDS    = 5'd6,
    ST_FIRST_OFF = 5'd7,
    ST_ORDER     = 5'd8,
    ST_TERMINAL  = 5'd9,
    ST_NONPRINT  = 5'd10,
    ST_UNTERM    = 5'd11,
    ST_EMPTY     = 5'd12,
    ST_LONG      = 5'd13,
    ST_PADDING   = 5'd14,
    ST_LENGTH    = 5'd15,
    ST_EXACT_END = 5'd16
  } status_e;

  localparam logic [1:0] RegArchiveSize = 2'd0;
  localparam logic [1:0] RegExactEnd    = 2'd1;

  typedef struct packed {
    logic        has_entry;
    logic [19:0] e_index;
    logic [32:0] e_offset;
    logic [31:0] e_size;
    logic        has_name;
    logic [19:0] n_index;
    logic [25:0] n_start;
    logic [12:0] n_length;
    logic        has_status;
    logic [4:0]  status;
    logic [32:0] used_bytes;
  } work_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [19:0] entry_index;
    logic [32:0] entry_start;
    logic [31:0] entry_size;
    logic [25:0] name_start;
    logic [12:0] name_length;
    logic [4:0]  status;
    logic [32:0] used_bytes;
    logic        final_res;
  } rec_t;
endpackage

// File: design/adv_front.sv
`timescale 1ns / 1ps
module adv_front #(
  parameter int unsigned MAX_ENTRIES   = adv_pkg::DefMaxEntries,
  parameter int unsigned MAX_NAME_LEN  = adv_pkg::DefMaxNameLen,
  parameter int unsigned MAX_DIR_BYTES = adv_pkg::DefMaxDirBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      byte_value_i,
  input  logic            last_i,
  input  logic [63:0]     arc_bytes_i,
  input  logic            exact_end_i,
  output logic            work_valid_o,
  input  logic            work_stall_i,
  output adv_pkg::work_t  work_o
);
  import adv_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_DIR_BYTES + 1);
  localparam int unsigned LenW = $clog2(MAX_NAME_LEN + 2);

  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] count_q, count_d;
  logic [31:0] table_q, table_d;
  logic [31:0] names_q, names_d;
  logic [31:0] data_q, data_d;
  logic [31:0] prev_q, prev_d;
  logic [20:0] oidx_q, oidx_d;
  logic [20:0] nidx_q, nidx_d;
  logic [25:0] nstart_q, nstart_d;
  logic [LenW-1:0] nlen_q, nlen_d;
  logic [4:0] err_q, err_d;
  logic [32:0] term_q, term_d;

  logic        accept;
  work_t       w;
  logic [63:0] p64;
  logic [63:0] expect_names;
  logic [32:0] tb;
  logic [63:0] s64;
  logic [4:0]  st;

  assign in_stall_o = work_stall_i;
  assign accept = in_valid_i && !work_stall_i;
  assign p64 = 64'(pos_q);

  always_comb begin
    pos_d = pos_q; count_d = count_q; table_d = table_q; names_d = names_q;
    data_d = data_q; prev_d = prev_q; oidx_d = oidx_q; nidx_d = nidx_q;
    nstart_d = nstart_q; nlen_d = nlen_q; err_d = err_q; term_d = term_q;
    w = '0;
    tb = '0;
    s64 = '0;
    st = ST_OK;
    expect_names = 64'(HdrBytes) + 64'd4 * (64'(count_q) + 64'd1);
    shift_d = {byte_value_i, shift_q[31:8]};
    if (p64 < 64'(HdrBytes)) begin
      if (pos_q[1:0] == 2'd3) begin
        case (p64[4:2])
          3'd1: count_d = shift_d;
          3'd2: table_d = shift_d;
          3'd3: names_d = shift_d;
          3'd4: data_d = shift_d;
          default: ;
        endcase
      end
      if (p64 == 64'(HdrBytes - 1)) begin
        if (table_q != 32'(HdrBytes)) err_d = ST_TABLE;
        else if (64'(count_q) > 64'(MAX_ENTRIES)) err_d = ST_COUNT;
        else if (64'(shift_d) > 64'(MAX_DIR_BYTES)) err_d = ST_DIR_LIMIT;
        else if (expect_names > 64'hFFFF_FFFF || 64'(names_q) != expect_names)
          err_d = ST_NAMES;
        else if (names_q > shift_d || 64'(shift_d) > arc_bytes_i) err_d = ST_BOUNDS;
        else err_d = ST_OK;
      end
    end else if (err_q == ST_OK && p64 < 64'(data_q)) begin
      if (p64 < 64'(names_q)) begin
        if (pos_q[1:0] == 2'd3) begin
          if (oidx_q == '0) begin
            if (shift_d != '0) err_d = ST_FIRST_OFF;
          end else if (shift_d < prev_q) begin
            err_d = ST_ORDER;
          end else begin
            w.has_entry = 1'b1;
            w.e_index = 20'(oidx_q - 21'd1);
            w.e_offset = 33'(data_q) + 33'(prev_q);
            w.e_size = shift_d - prev_q;
          end
          tb = 33'(data_q) + 33'(shift_d);
          if (err_d == ST_OK && 32'(oidx_q) == count_q) begin
            term_d = tb;
            if (64'(tb) > arc_bytes_i) err_d = ST_TERMINAL;
          end
          prev_d = shift_d;
          oidx_d = oidx_q + 21'd1;
        end
      end else if (32'(nidx_q) < count_q) begin
        if (nlen_q == '0) nstart_d = 26'(pos_q);
        if (byte_value_i == 8'd0) begin
          if (nlen_q == '0) err_d = ST_EMPTY;
          else if (32'(nlen_q) > 32'(MAX_NAME_LEN)) err_d = ST_LONG;
          else begin
            w.has_name = 1'b1;
            w.n_index = 20'(nidx_q);
            w.n_start = nstart_d;
            w.n_length = 13'(nlen_q);
            nidx_d = nidx_q + 21'd1;
            nlen_d = '0;
          end
        end else if (byte_value_i < 8'h20 || byte_value_i > 8'h7E) begin
          err_d = ST_NONPRINT;
        end else if (32'(nlen_q) <= 32'(MAX_NAME_LEN)) begin
          nlen_d = nlen_q + LenW'(1);
        end
      end else if (byte_value_i != 8'd0) begin
        err_d = ST_PADDING;
      end
      if (err_d == ST_OK && p64 + 64'd1 == 64'(data_q) && 32'(nidx_d) < count_q)
        err_d = ST_UNTERM;
    end
    if (p64 < 64'(MAX_DIR_BYTES)) pos_d = pos_q + PosW'(1);
    if (last_i) begin
      s64 = 64'(pos_d);
      if (s64 < 64'(HdrBytes + 4)) st = ST_SHORT;
      else if (err_d >= ST_TABLE && err_d <= ST_NAMES) st = err_d;
      else if (err_d == ST_BOUNDS || 64'(data_d) > s64) st = ST_BOUNDS;
      else if (err_d != ST_OK) st = err_d;
      else if (exact_end_i && 64'(term_d) != arc_bytes_i) st = ST_EXACT_END;
      else st = ST_OK;
      w.has_status = 1'b1;
      w.status = st;
      w.used_bytes = (st == ST_OK || st == ST_EXACT_END) ? term_d : '0;
      pos_d = '0; count_d = '0; table_d = '0; names_d = '0; data_d = '0;
      prev_d = '0; oidx_d = '0; nidx_d = '0; nstart_d = '0; nlen_d = '0;
      err_d = ST_OK; term_d = '0; shift_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; shift_q <= '0; count_q <= '0; table_q <= '0; names_q <= '0;
      data_q <= '0; prev_q <= '0; oidx_q <= '0; nidx_q <= '0; nstart_q <= '0;
      nlen_q <= '0; err_q <= ST_OK; term_q <= '0;
      work_valid_o <= 1'b0;
    end else if (!work_stall_i) begin
      work_valid_o <= in_valid_i && (w.has_entry || w.has_name || w.has_status);
      if (in_valid_i) begin
        pos_q <= pos_d; shift_q <= shift_d; count_q <= count_d; table_q <= table_d;
        names_q <= names_d; data_q <= data_d; prev_q <= prev_d; oidx_q <= oidx_d;
        nidx_q <= nidx_d; nstart_q <= nstart_d; nlen_q <= nlen_d; err_q <= err_d;
        term_q <= term_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) work_o <= w;
  end
endmodule

// File: design/adv_queue.sv
`timescale 1ns / 1ps
module adv_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_stall_o,
  input  adv_pkg::work_t push_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output adv_pkg::work_t pop_o
);
  import adv_pkg::*;

  work_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign push_stall_o = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign push = push_valid_i && !push_stall_o;
  assign pop = pop_valid_o && pop_ready_i;
  assign pop_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_i;
  end
endmodule

// File: design/adv_back.sv
`timescale 1ns / 1ps
module adv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           work_valid_i,
  output logic           work_ready_o,
  input  adv_pkg::work_t work_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output adv_pkg::rec_t  rec_o
);
  import adv_pkg::*;

  logic [1:0] done_q, done_d;
  logic       send;
  rec_t       r;
  logic       take_e, take_n, take_s;

  always_comb begin
    take_e = work_i.has_entry && !done_q[0];
    take_n = work_i.has_name && !done_q[1];
    take_s = !take_e && !take_n && work_i.has_status;
    r = '0;
    if (take_e) begin
      r.kind = KIND_ENTRY;
      r.entry_index = work_i.e_index;
      r.entry_start = work_i.e_offset;
      r.entry_size = work_i.e_size;
    end else if (take_n) begin
      r.kind = KIND_NAME;
      r.entry_index = work_i.n_index;
      r.name_start = work_i.n_start;
      r.name_length = work_i.n_length;
    end else begin
      r.kind = KIND_STATUS;
      r.status = work_i.status;
      r.used_bytes = work_i.used_bytes;
      r.final_res = 1'b1;
    end
    done_d = done_q;
    if (take_e) done_d[0] = 1'b1;
    if (take_n) done_d[1] = 1'b1;
    work_ready_o = 1'b0;
    if (work_valid_i && !(out_valid_o && out_stall_i)) begin
      if (take_s || (take_e && !work_i.has_name && !work_i.has_status) ||
          (take_n && !work_i.has_status)) begin
        work_ready_o = 1'b1;
        done_d = '0;
      end
    end
  end

  assign send = work_valid_i && !(out_valid_o && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      done_q <= '0;
    end else if (!(out_valid_o && out_stall_i)) begin
      out_valid_o <= work_valid_i;
      if (work_valid_i) done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (send) rec_o <= r;
  end
endmodule

// File: design/archive_directory_validator_core.sv
`timescale 1ns / 1ps
// channel | valid       | stall       | payload
// in      | in_valid_i  | in_stall_o  | byte_value_i, last_i
// out     | out_valid_o | out_stall_i | kind_o .. final_res_o
// One byte item per cycle enters the parser while in_stall_o is low; each item is
// classified combinationally and registered. An item giving an entry or name plus
// the status gives two records at the back end; the two-entry queue absorbs that.
// A result passes the front work register, the queue and the back-end record register.
// Reset clears all parser state and the queue; the archive size is 0, exact_end is 1.
// in_stall_o rises only when the queue is full.
module archive_directory_validator_core #(
  parameter int unsigned MAX_ENTRIES   = adv_pkg::DefMaxEntries,
  parameter int unsigned MAX_NAME_LEN  = adv_pkg::DefMaxNameLen,
  parameter int unsigned MAX_DIR_BYTES = adv_pkg::DefMaxDirBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [19:0] entry_index_o,
  output logic [32:0] entry_start_o,
  output logic [31:0] entry_size_o,
  output logic [25:0] name_start_o,
  output logic [12:0] name_length_o,
  output logic [4:0]  status_o,
  output logic [32:0] used_bytes_o,
  output logic        final_res_o
);
  import adv_pkg::*;

  logic [63:0] arc_bytes_q;
  logic        exact_end_q;
  logic        fw_valid, fw_stall, q_valid, q_ready;
  work_t       fw, qw;
  rec_t        rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arc_bytes_q <= '0;
      exact_end_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegArchiveSize: arc_bytes_q <= cfg_wdata_i;
        RegExactEnd:    exact_end_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  adv_front #(
    .MAX_ENTRIES(MAX_ENTRIES), .MAX_NAME_LEN(MAX_NAME_LEN), .MAX_DIR_BYTES(MAX_DIR_BYTES)
  ) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .byte_value_i, .last_i,
    .arc_bytes_i(arc_bytes_q), .exact_end_i(exact_end_q),
    .work_valid_o(fw_valid), .work_stall_i(fw_stall), .work_o(fw)
  );

  adv_queue u_queue (
    .clk_i, .rst_ni, .push_valid_i(fw_valid), .push_stall_o(fw_stall), .push_i(fw),
    .pop_valid_o(q_valid), .pop_ready_i(q_ready), .pop_o(qw)
  );

  adv_back u_back (
    .clk_i, .rst_ni, .work_valid_i(q_valid), .work_ready_o(q_ready), .work_i(qw),
    .out_valid_o, .out_stall_i, .rec_o(rec)
  );

  assign kind_o = rec.kind;
  assign entry_index_o = rec.entry_index;
  assign entry_start_o = rec.entry_start;
  assign entry_size_o = rec.entry_size;
  assign name_start_o = rec.name_start;
  assign name_length_o = rec.name_length;
  assign status_o = rec.status;
  assign used_bytes_o = rec.used_bytes;
  assign final_res_o = rec.final_res;

  a_final_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (final_res_o == (kind_o == KIND_STATUS)))
    else $error("final flag and kind disagree");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_STATUS) |-> (status_o <= ST_EXACT_END))
    else $error("status out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped under stall");
endmodule
